[src/gdp_pkg.sv]
// ----------------------------------------------------------------------------
// gdp_pkg
// Shared types and constants of the grid shortest-path block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdp_pkg;

  localparam int MAX_ROWS_DEF  = 8;
  localparam int MAX_COLS_DEF  = 8;
  localparam int COST_BITS_DEF = 16;

  localparam int COORD_BITS   = 3;
  localparam int DIM_BITS     = 4;
  localparam int MODE_BITS    = 2;
  localparam int COST_IN_BITS = 16;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 4'd8;

  // input item modes
  localparam logic [MODE_BITS-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_FILL  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_QUERY = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLS = 1'b1;

  // neighbor visiting order
  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_LEFT  = 2'd1;
  localparam logic [1:0] NB_DOWN  = 2'd2;
  localparam logic [1:0] NB_RIGHT = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_INIT,
    OP_SCAN_START,
    OP_SCAN,
    OP_VISIT,
    OP_NB_RD,
    OP_NB_SKIP,
    OP_NB_WR,
    OP_PATH_WR,
    OP_PATH_LD,
    OP_EMIT_LD,
    OP_NF_LD
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic range_bad;
    logic scan_done;
    logic have;
    logic u_is_goal;
    logic nb_ok;
    logic nb_last;
    logic path_end;
    logic out_taken;
    logic out_last;
  } status_t;

endpackage

`default_nettype wire

[src/gdp_ifs.sv]
// ----------------------------------------------------------------------------
// gdp channel interfaces
// Input item, result item and config write channels, valid/ready each.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdp_in_if import gdp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODE_BITS-1:0]    mode;
  logic [COORD_BITS-1:0]   cell_row;
  logic [COORD_BITS-1:0]   cell_col;
  logic [COST_IN_BITS-1:0] cost;
  logic [COORD_BITS-1:0]   start_row;
  logic [COORD_BITS-1:0]   start_col;
  logic [COORD_BITS-1:0]   goal_row;
  logic [COORD_BITS-1:0]   goal_col;

  modport source (output valid, mode, cell_row, cell_col, cost, start_row, start_col,
                  goal_row, goal_col, input ready);
  modport sink (input valid, mode, cell_row, cell_col, cost, start_row, start_col,
                goal_row, goal_col, output ready);
endinterface

interface gdp_out_if import gdp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] path_row;
  logic [COORD_BITS-1:0] path_col;
  logic                  found;
  logic                  last;

  modport source (output valid, path_row, path_col, found, last, input ready);
  modport sink (input valid, path_row, path_col, found, last, output ready);
endinterface

interface gdp_cfg_if import gdp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [DIM_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/gdp_ctrl.sv]
// ----------------------------------------------------------------------------
// gdp_ctrl
// Sequencer of the search: scan rounds, relaxation, path walk, emission.
// ----------------------------------------------------------------------------
`default_nettype none

module gdp_ctrl import gdp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [MODE_BITS-1:0] in_mode_i,
  input  status_t              stat_i,
  output cmd_t                 cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_SCAN_START, ST_SCAN, ST_VISIT, ST_NB_RD, ST_NB_WR,
    ST_PATH_WR, ST_PATH_RD, ST_PATH_LD, ST_EMIT_RD, ST_EMIT_LD, ST_NF_LD, ST_OUT_WAIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        cmd_o.op = OP_ACCEPT;
        if (in_valid_i && in_mode_i == MODE_QUERY) state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.op = OP_INIT;
        state_d  = stat_i.range_bad ? ST_NF_LD : ST_SCAN_START;
      end
      ST_SCAN_START: begin
        cmd_o.op = OP_SCAN_START;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (stat_i.scan_done) state_d = ST_VISIT;
      end
      ST_VISIT: begin
        if (!stat_i.have) begin
          state_d = ST_NF_LD;
        end else begin
          cmd_o.op = OP_VISIT;
          state_d  = stat_i.u_is_goal ? ST_PATH_WR : ST_NB_RD;
        end
      end
      ST_NB_RD: begin
        if (stat_i.nb_ok) begin
          cmd_o.op = OP_NB_RD;
          state_d  = ST_NB_WR;
        end else begin
          cmd_o.op = OP_NB_SKIP;
          state_d  = stat_i.nb_last ? ST_SCAN_START : ST_NB_RD;
        end
      end
      ST_NB_WR: begin
        cmd_o.op = OP_NB_WR;
        state_d  = stat_i.nb_last ? ST_SCAN_START : ST_NB_RD;
      end
      ST_PATH_WR: begin
        cmd_o.op = OP_PATH_WR;
        state_d  = stat_i.path_end ? ST_EMIT_RD : ST_PATH_RD;
      end
      ST_PATH_RD: state_d = ST_PATH_LD;
      ST_PATH_LD: begin
        cmd_o.op = OP_PATH_LD;
        state_d  = ST_PATH_WR;
      end
      ST_EMIT_RD: state_d = ST_EMIT_LD;
      ST_EMIT_LD: begin
        cmd_o.op = OP_EMIT_LD;
        state_d  = ST_OUT_WAIT;
      end
      ST_NF_LD: begin
        cmd_o.op = OP_NF_LD;
        state_d  = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (stat_i.out_taken) state_d = stat_i.out_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/gdp_dpath.sv]
// ----------------------------------------------------------------------------
// gdp_dpath
// Cost, distance, predecessor and path memories with scan and relax logic.
// ----------------------------------------------------------------------------
`default_nettype none

module gdp_dpath import gdp_pkg::*; #(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int COST_BITS = COST_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  output status_t   stat_o,
  gdp_in_if.sink    in_i,
  gdp_out_if.source out_o,
  gdp_cfg_if.sink   cfg_i
);

  localparam int CELLS     = MAX_ROWS * MAX_COLS;
  localparam int CELL_BITS = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_BITS  = CELL_BITS + 1;
  localparam int DIST_BITS = COST_BITS + CELL_BITS;
  localparam int RC_BITS   = 2 * COORD_BITS;

  function automatic logic [CELL_BITS-1:0] to_idx(input logic [COORD_BITS-1:0] r,
                                                  input logic [COORD_BITS-1:0] c,
                                                  input logic [DIM_BITS-1:0]   w);
    logic [COORD_BITS+DIM_BITS-1:0] p;
    p = ({{DIM_BITS{1'b0}}, r} * {{COORD_BITS{1'b0}}, w}) + {{DIM_BITS{1'b0}}, c};
    return p[CELL_BITS-1:0];
  endfunction

  // config
  logic [DIM_BITS-1:0] rows_q, cols_q, rows_eff, cols_eff;
  logic [2*DIM_BITS-1:0] n_full;
  logic [CNT_BITS-1:0] n_cnt;

  // memories
  logic [COST_BITS-1:0] cost_mem [CELLS];
  logic [DIST_BITS-1:0] dist_mem [CELLS];
  logic [RC_BITS-1:0]   pred_mem [CELLS];
  logic [RC_BITS-1:0]   pbuf_mem [CELLS];
  logic [CELLS-1:0]     cvalid_q, reached_q, visited_q;
  logic [COST_BITS-1:0] fill_q, crd_q;
  logic                 cval_q;
  logic [DIST_BITS-1:0] dist_rd_q;
  logic [RC_BITS-1:0]   pred_rd_q, pb_rd_q;

  // query
  logic [COORD_BITS-1:0] sr_q, sc_q, gr_q, gc_q;
  logic [CELL_BITS-1:0]  s_idx, g_idx, w_idx;
  logic                  in_fire, range_bad;

  // scan
  logic [CNT_BITS-1:0]   scan_i_q;
  logic [COORD_BITS-1:0] sc_r_q, sc_c_q, p_r_q, p_c_q, u_r_q, u_c_q;
  logic [CELL_BITS-1:0]  p_idx_q, u_idx_q;
  logic                  p_valid_q, have_q, issue, cand;
  logic [DIST_BITS-1:0]  best_q;

  // relax
  logic [1:0]            nb_q;
  logic                  nb_ok;
  logic [CELL_BITS-1:0]  v_idx, v_q, cols_c, rd_addr;
  logic [COST_BITS-1:0]  cost_v;
  logic [DIST_BITS-1:0]  alt;
  logic                  better;

  // path and output
  logic [COORD_BITS-1:0] cur_r_q, cur_c_q;
  logic [CELL_BITS-1:0]  cur_idx, e_q;
  logic [CNT_BITS-1:0]   len_q;
  logic                  out_valid_q, out_found_q, out_last_q, out_taken;
  logic [COORD_BITS-1:0] out_row_q, out_col_q;

  always_comb begin
    rows_eff = rows_q;
    if (rows_q == '0) rows_eff = DIM_BITS'(1);
    else if (rows_q > DIM_BITS'(MAX_ROWS)) rows_eff = DIM_BITS'(MAX_ROWS);
    cols_eff = cols_q;
    if (cols_q == '0) cols_eff = DIM_BITS'(1);
    else if (cols_q > DIM_BITS'(MAX_COLS)) cols_eff = DIM_BITS'(MAX_COLS);
  end

  assign n_full  = rows_eff * cols_eff;
  assign n_cnt   = n_full[CNT_BITS-1:0];
  assign cols_c  = CELL_BITS'(cols_eff);

  assign in_i.ready  = (cmd_i.op == OP_ACCEPT);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign s_idx   = to_idx(sr_q, sc_q, cols_eff);
  assign g_idx   = to_idx(gr_q, gc_q, cols_eff);
  assign w_idx   = to_idx(in_i.cell_row, in_i.cell_col, cols_eff);
  assign cur_idx = to_idx(cur_r_q, cur_c_q, cols_eff);

  assign range_bad = (DIM_BITS'(sr_q) >= rows_eff) || (DIM_BITS'(sc_q) >= cols_eff) ||
                     (DIM_BITS'(gr_q) >= rows_eff) || (DIM_BITS'(gc_q) >= cols_eff);

  assign issue = (cmd_i.op == OP_SCAN) && (scan_i_q < n_cnt);
  assign cand  = p_valid_q && reached_q[p_idx_q] && !visited_q[p_idx_q] &&
                 (!have_q || dist_rd_q < best_q);

  always_comb begin
    nb_ok = 1'b0;
    v_idx = u_idx_q;
    case (nb_q)
      NB_UP: begin
        nb_ok = (u_r_q != '0);
        v_idx = u_idx_q - cols_c;
      end
      NB_LEFT: begin
        nb_ok = (u_c_q != '0);
        v_idx = u_idx_q - CELL_BITS'(1);
      end
      NB_DOWN: begin
        nb_ok = (DIM_BITS'(u_r_q) + DIM_BITS'(1)) < rows_eff;
        v_idx = u_idx_q + cols_c;
      end
      NB_RIGHT: begin
        nb_ok = (DIM_BITS'(u_c_q) + DIM_BITS'(1)) < cols_eff;
        v_idx = u_idx_q + CELL_BITS'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign rd_addr = (cmd_i.op == OP_NB_RD) ? v_idx : scan_i_q[CELL_BITS-1:0];
  assign cost_v  = cval_q ? crd_q : fill_q;
  assign alt     = best_q + DIST_BITS'(cost_v);
  assign better  = !reached_q[v_q] || (alt < dist_rd_q);
  assign out_taken = out_valid_q && out_o.ready;

  assign stat_o.range_bad = range_bad;
  assign stat_o.scan_done = (scan_i_q >= n_cnt) && !p_valid_q;
  assign stat_o.have      = have_q;
  assign stat_o.u_is_goal = (u_idx_q == g_idx);
  assign stat_o.nb_ok     = nb_ok;
  assign stat_o.nb_last   = (nb_q == NB_RIGHT);
  assign stat_o.path_end  = ((cur_r_q == sr_q) && (cur_c_q == sc_q)) ||
                            (len_q == CNT_BITS'(CELLS - 1));
  assign stat_o.out_taken = out_taken;
  assign stat_o.out_last  = out_last_q;

  assign out_o.valid    = out_valid_q;
  assign out_o.path_row = out_row_q;
  assign out_o.path_col = out_col_q;
  assign out_o.found    = out_found_q;
  assign out_o.last     = out_last_q;

  // memories
  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.mode == MODE_WRITE &&
        DIM_BITS'(in_i.cell_row) < rows_eff && DIM_BITS'(in_i.cell_col) < cols_eff) begin
      cost_mem[w_idx] <= COST_BITS'(in_i.cost);
    end
    crd_q <= cost_mem[v_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_INIT && !range_bad) begin
      dist_mem[s_idx] <= '0;
      pred_mem[s_idx] <= {sr_q, sc_q};
    end else if (cmd_i.op == OP_NB_WR && better) begin
      dist_mem[v_q] <= alt;
      pred_mem[v_q] <= {u_r_q, u_c_q};
    end
    dist_rd_q <= dist_mem[rd_addr];
    pred_rd_q <= pred_mem[cur_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PATH_WR) pbuf_mem[len_q[CELL_BITS-1:0]] <= {cur_r_q, cur_c_q};
    pb_rd_q <= pbuf_mem[e_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sr_q <= in_i.start_row;
      sc_q <= in_i.start_col;
      gr_q <= in_i.goal_row;
      gc_q <= in_i.goal_col;
    end
    p_idx_q <= scan_i_q[CELL_BITS-1:0];
    p_r_q   <= sc_r_q;
    p_c_q   <= sc_c_q;
    if (cand) begin
      best_q  <= dist_rd_q;
      u_idx_q <= p_idx_q;
      u_r_q   <= p_r_q;
      u_c_q   <= p_c_q;
    end
    if (cmd_i.op == OP_NB_RD) v_q <= v_idx;
    case (cmd_i.op)
      OP_VISIT: begin
        cur_r_q <= gr_q;
        cur_c_q <= gc_q;
      end
      OP_PATH_LD: {cur_r_q, cur_c_q} <= pred_rd_q;
      OP_EMIT_LD: begin
        out_row_q   <= pb_rd_q[RC_BITS-1:COORD_BITS];
        out_col_q   <= pb_rd_q[COORD_BITS-1:0];
        out_found_q <= 1'b1;
        out_last_q  <= (e_q == '0);
      end
      OP_NF_LD: begin
        out_row_q   <= '0;
        out_col_q   <= '0;
        out_found_q <= 1'b0;
        out_last_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= DIM_RESET;
      cols_q      <= DIM_RESET;
      cvalid_q    <= '0;
      cval_q      <= 1'b0;
      fill_q      <= '0;
      reached_q   <= '0;
      visited_q   <= '0;
      scan_i_q    <= '0;
      sc_r_q      <= '0;
      sc_c_q      <= '0;
      p_valid_q   <= 1'b0;
      have_q      <= 1'b0;
      nb_q        <= NB_UP;
      len_q       <= '0;
      e_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == CFG_ROWS) rows_q <= cfg_i.data;
        if (cfg_i.index == CFG_COLS) cols_q <= cfg_i.data;
      end
      cval_q <= cvalid_q[v_idx];
      if (in_fire && in_i.mode == MODE_FILL) begin
        cvalid_q <= '0;
        fill_q   <= COST_BITS'(in_i.cost);
      end else if (in_fire && in_i.mode == MODE_WRITE &&
                   DIM_BITS'(in_i.cell_row) < rows_eff &&
                   DIM_BITS'(in_i.cell_col) < cols_eff) begin
        cvalid_q[w_idx] <= 1'b1;
      end
      // issue is low outside the scan, so this also clears it at scan start
      p_valid_q <= issue;
      if (cand) have_q <= 1'b1;
      if (issue) begin
        scan_i_q <= scan_i_q + CNT_BITS'(1);
        if ((DIM_BITS'(sc_c_q) + DIM_BITS'(1)) == cols_eff) begin
          sc_c_q <= '0;
          sc_r_q <= sc_r_q + COORD_BITS'(1);
        end else begin
          sc_c_q <= sc_c_q + COORD_BITS'(1);
        end
      end
      if (out_taken) begin
        out_valid_q <= 1'b0;
        e_q         <= e_q - CELL_BITS'(1);
      end
      case (cmd_i.op)
        OP_INIT: begin
          visited_q <= '0;
          reached_q <= range_bad ? '0 : (CELLS'(1) << s_idx);
        end
        OP_SCAN_START: begin
          scan_i_q  <= '0;
          sc_r_q    <= '0;
          sc_c_q    <= '0;
          have_q    <= 1'b0;
        end
        OP_VISIT: begin
          visited_q[u_idx_q] <= 1'b1;
          nb_q  <= NB_UP;
          len_q <= '0;
        end
        OP_NB_SKIP: nb_q <= nb_q + 2'd1;
        OP_NB_WR: begin
          nb_q <= nb_q + 2'd1;
          if (better) reached_q[v_q] <= 1'b1;
        end
        OP_PATH_WR: begin
          len_q <= len_q + CNT_BITS'(1);
          e_q   <= len_q[CELL_BITS-1:0];
        end
        OP_EMIT_LD, OP_NF_LD: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // a cell is only ever visited after it was reached
  a_visit_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (visited_q & ~reached_q) == '0)
    else $error("visited cell not reached");

  a_visit_have: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_VISIT |-> have_q)
    else $error("visit without a scan winner");

  a_nf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> out_last_q)
    else $error("not-found result not marked last");

  a_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !out_valid_q)
    else $error("item accepted while a result is pending");

endmodule

`default_nettype wire

[src/grid_dijkstra_path.sv]
// ----------------------------------------------------------------------------
// grid_dijkstra_path
// Dijkstra shortest path over a 4-connected grid of cell entry costs.
// ----------------------------------------------------------------------------
// A fill clears the per-cell valid bits and latches the fill cost; unwritten
// cells read that cost. A query runs in rounds, n = rows * cols: each round
// has a setup step, scans all n distances through the single read port of
// the distance memory, one cell a cycle, then drains the read pipeline,
// visits the chosen cell and walks four neighbor slots: a slot off the grid
// is skipped, a neighbor on the grid is read, then compared and written.
// The path is walked back through the predecessor memory into a buffer
// (write, read, then load for each cell) and then sent start first, one
// result per transfer; a new item is taken once the last result of a query
// has been transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_dijkstra_path import gdp_pkg::*; #(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int COST_BITS = COST_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gdp_in_if.sink    in_i,
  gdp_out_if.source out_o,
  gdp_cfg_if.sink   cfg_i
);

  cmd_t    cmd;
  status_t stat;

  // sequencer: owns the search order, drives one command per cycle
  gdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: memories, scan minimum, relax compare, path buffer, output reg
  gdp_dpath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .COST_BITS (COST_BITS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i)
  );

endmodule

`default_nettype wire

[dv/gdp_tb_ifs.sv]
// ----------------------------------------------------------------------------
// gdp testbench channel note
// The block's channel interfaces come from the RTL; this file adds nothing
// but a small package of test-side types shared by the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdp_tb_pkg;
  import gdp_pkg::*;

  typedef struct packed {
    logic [MODE_BITS-1:0]    mode;
    logic [COORD_BITS-1:0]   cell_row;
    logic [COORD_BITS-1:0]   cell_col;
    logic [COST_IN_BITS-1:0] cost;
    logic [COORD_BITS-1:0]   start_row;
    logic [COORD_BITS-1:0]   start_col;
    logic [COORD_BITS-1:0]   goal_row;
    logic [COORD_BITS-1:0]   goal_col;
  } grid_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] path_row;
    logic [COORD_BITS-1:0] path_col;
    logic                  found;
    logic                  last;
  } path_cell_t;
endpackage

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grid_dijkstra_path: cell writes, fills and path
// queries are driven through valid/ready, every emitted path cell is checked
// against an in-bench shortest-path predictor, across several grid sizes and
// idle/stall phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import gdp_pkg::*;
  import gdp_tb_pkg::*;

  localparam int NCELL = 64;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  gdp_in_if  in_ch ();
  gdp_out_if out_ch ();
  gdp_cfg_if cfg_ch ();

  grid_dijkstra_path dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // predictor state
  logic [15:0] grid_cost [NCELL];
  logic [3:0]  rows_reg = DIM_RESET;
  logic [3:0]  cols_reg = DIM_RESET;

  grid_item_t item_q[$];
  path_cell_t path_q[$];

  // stimulus control
  int  src_idle_pct = 0;
  int  snk_stall_pct = 0;
  bit  hold_src = 1'b0;
  int  n_err = 0;
  int  n_cells = 0;
  int  n_items = 0;
  int  n_queries = 0;
  int  n_notfound = 0;

  function automatic int eff_dim(logic [3:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return v;
  endfunction

  function automatic void queue_cell(path_cell_t pc);
    path_q = {path_q, pc};
  endfunction

  function automatic void queue_item(grid_item_t it);
    item_q = {item_q, it};
  endfunction

  // Dijkstra with lowest-index tie break, neighbors up/left/down/right,
  // strictly-better relaxation only.
  function automatic void predict_path(grid_item_t it);
    int rows, cols, n, s, g, u, r, c, len, cur;
    longint dist_acc [NCELL];
    bit reach [NCELL];
    bit seen [NCELL];
    int pred [NCELL];
    int trail [NCELL];
    int nb [4];
    bit ok [4];
    bit have;
    path_cell_t pc;
    rows = eff_dim(rows_reg);
    cols = eff_dim(cols_reg);
    n = rows * cols;
    pc.path_row = '0;
    pc.path_col = '0;
    pc.found = 1'b0;
    pc.last = 1'b1;
    if (it.start_row >= rows || it.start_col >= cols ||
        it.goal_row >= rows || it.goal_col >= cols) begin
      queue_cell(pc);
      return;
    end
    s = it.start_row * cols + it.start_col;
    g = it.goal_row * cols + it.goal_col;
    for (int i = 0; i < NCELL; i++) begin
      reach[i] = 0;
      seen[i] = 0;
      dist_acc[i] = 0;
      pred[i] = 0;
    end
    reach[s] = 1;
    pred[s] = s;
    forever begin
      have = 0;
      u = 0;
      for (int i = 0; i < n; i++) begin
        if (seen[i] || !reach[i]) continue;
        if (!have || dist_acc[i] < dist_acc[u]) begin
          have = 1;
          u = i;
        end
      end
      if (!have) break;
      seen[u] = 1;
      if (u == g) break;
      r = u / cols;
      c = u % cols;
      nb[0] = u - cols; ok[0] = r > 0;
      nb[1] = u - 1;    ok[1] = c > 0;
      nb[2] = u + cols; ok[2] = r + 1 < rows;
      nb[3] = u + 1;    ok[3] = c + 1 < cols;
      for (int k = 0; k < 4; k++) begin
        if (ok[k] && (!reach[nb[k]] ||
                      dist_acc[u] + grid_cost[nb[k]] < dist_acc[nb[k]])) begin
          dist_acc[nb[k]] = dist_acc[u] + grid_cost[nb[k]];
          reach[nb[k]] = 1;
          pred[nb[k]] = u;
        end
      end
    end
    if (!seen[g]) begin
      n_notfound++;
      queue_cell(pc);
      return;
    end
    len = 0;
    cur = g;
    while (len < NCELL) begin
      trail[len++] = cur;
      if (cur == s) break;
      cur = pred[cur];
    end
    for (int i = 0; i < len; i++) begin
      pc.path_row = COORD_BITS'(trail[len - 1 - i] / cols);
      pc.path_col = COORD_BITS'(trail[len - 1 - i] % cols);
      pc.found = 1'b1;
      pc.last = (i + 1 == len);
      queue_cell(pc);
    end
  endfunction

  function automatic void apply_item(grid_item_t it);
    int rows, cols;
    rows = eff_dim(rows_reg);
    cols = eff_dim(cols_reg);
    case (it.mode)
      MODE_WRITE: begin
        if (it.cell_row < rows && it.cell_col < cols)
          grid_cost[it.cell_row * cols + it.cell_col] = it.cost;
      end
      MODE_FILL: begin
        for (int i = 0; i < NCELL; i++) grid_cost[i] = it.cost;
      end
      MODE_QUERY: begin
        n_queries++;
        predict_path(it);
      end
      default: ;
    endcase
  endfunction

  // driver: one nonblocking update of valid per edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= '0;
      in_ch.cell_row <= '0;
      in_ch.cell_col <= '0;
      in_ch.cost <= '0;
      in_ch.start_row <= '0;
      in_ch.start_col <= '0;
      in_ch.goal_row <= '0;
      in_ch.goal_col <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_item({in_ch.mode, in_ch.cell_row, in_ch.cell_col, in_ch.cost,
                    in_ch.start_row, in_ch.start_col, in_ch.goal_row, in_ch.goal_col});
        n_items++;
      end
      if ((!in_ch.valid || in_ch.ready)) begin
        if (item_q.size() > 0 && !hold_src && $urandom_range(99) >= src_idle_pct) begin
          grid_item_t it;
          it = item_q.pop_front();
          in_ch.valid <= 1'b1;
          {in_ch.mode, in_ch.cell_row, in_ch.cell_col, in_ch.cost, in_ch.start_row,
           in_ch.start_col, in_ch.goal_row, in_ch.goal_col} <= it;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        path_cell_t want;
        n_cells++;
        if (path_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("unexpected path cell r%0d c%0d f%0d l%0d", out_ch.path_row,
                     out_ch.path_col, out_ch.found, out_ch.last);
        end else begin
          want = path_q.pop_front();
          if (want.path_row !== out_ch.path_row || want.path_col !== out_ch.path_col ||
              want.found !== out_ch.found || want.last !== out_ch.last) begin
            n_err++;
            if (n_err <= 10)
              $display("path cell mismatch: exp r%0d c%0d f%0d l%0d got r%0d c%0d f%0d l%0d",
                       want.path_row, want.path_col, want.found, want.last,
                       out_ch.path_row, out_ch.path_col, out_ch.found, out_ch.last);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // config write: only called while the block is idle
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [3:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_ROWS) rows_reg = val;
    else cols_reg = val;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (item_q.size() > 0 || in_ch.valid || path_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic grid_item_t rand_item(int rows, int cols);
    grid_item_t it;
    int pick;
    it = $bits(grid_item_t)'({$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 45) begin
      it.mode = MODE_WRITE;
      if ($urandom_range(9) != 0) begin
        it.cell_row = COORD_BITS'($urandom_range(rows - 1));
        it.cell_col = COORD_BITS'($urandom_range(cols - 1));
      end
      if ($urandom_range(3) != 0) it.cost = COST_IN_BITS'($urandom_range(20));
    end else if (pick < 50) begin
      it.mode = MODE_FILL;
      if ($urandom_range(1)) it.cost = COST_IN_BITS'($urandom_range(3));
    end else if (pick < 95) begin
      it.mode = MODE_QUERY;
      if ($urandom_range(9) != 0) begin
        it.start_row = COORD_BITS'($urandom_range(rows - 1));
        it.start_col = COORD_BITS'($urandom_range(cols - 1));
        it.goal_row = COORD_BITS'($urandom_range(rows - 1));
        it.goal_col = COORD_BITS'($urandom_range(cols - 1));
      end
    end else begin
      it.mode = MODE_UNUSED;
    end
    return it;
  endfunction

  task automatic run_phase(int cnt, int idle, int stall);
    src_idle_pct = idle;
    snk_stall_pct = stall;
    for (int i = 0; i < cnt; i++) queue_item(rand_item(eff_dim(rows_reg), eff_dim(cols_reg)));
    wait_drained();
  endtask

  // like run_phase, but once the first query is out the sender holds off until
  // every expected result has come back, then resumes
  task automatic run_held_phase(int cnt, int idle, int stall);
    src_idle_pct = idle;
    snk_stall_pct = stall;
    for (int i = 0; i < cnt; i++) queue_item(rand_item(eff_dim(rows_reg), eff_dim(cols_reg)));
    while (path_q.size() == 0 && (item_q.size() > 0 || in_ch.valid)) @(posedge clk_i);
    hold_src = 1'b1;
    while (path_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    hold_src = 1'b0;
    wait_drained();
  endtask

  function automatic grid_item_t mk(logic [1:0] m, int a, int b, logic [15:0] c,
                                    int sr, int sc, int gr, int gc);
    return {m, a[2:0], b[2:0], c, sr[2:0], sc[2:0], gr[2:0], gc[2:0]};
  endfunction

  initial begin
    for (int i = 0; i < NCELL; i++) grid_cost[i] = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ROWS;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero-cost grid, ties, extremes, high-cost walls, unused mode
    queue_item(mk(MODE_QUERY, 0, 0, 0, 0, 0, 7, 7));
    queue_item(mk(MODE_QUERY, 0, 0, 0, 3, 4, 3, 4));
    queue_item(mk(MODE_QUERY, 0, 0, 0, 7, 7, 0, 0));
    queue_item(mk(MODE_FILL, 0, 0, 16'hFFFF, 0, 0, 0, 0));
    queue_item(mk(MODE_QUERY, 0, 0, 0, 0, 7, 7, 0));
    queue_item(mk(MODE_WRITE, 7, 7, 0, 0, 0, 0, 0));
    queue_item(mk(MODE_WRITE, 3, 5, 16'h5555, 7, 7, 7, 7));
    queue_item(mk(MODE_WRITE, 5, 3, 16'hAAAA, 0, 0, 0, 0));
    queue_item(mk(MODE_QUERY, 7, 7, 16'hFFFF, 2, 2, 6, 6));
    queue_item(mk(MODE_UNUSED, 7, 7, 16'hFFFF, 7, 7, 7, 7));
    queue_item(mk(MODE_FILL, 0, 0, 1, 0, 0, 0, 0));
    queue_item(mk(MODE_QUERY, 0, 0, 0, 4, 0, 4, 7));
    wait_drained();

    // 2x3 grid, write outside, query outside, then a query inside the grid
    write_reg(CFG_ROWS, 4'd2);
    write_reg(CFG_COLS, 4'd3);
    queue_item(mk(MODE_WRITE, 2, 0, 9, 0, 0, 0, 0));
    queue_item(mk(MODE_QUERY, 0, 0, 0, 0, 0, 2, 0));
    queue_item(mk(MODE_QUERY, 0, 0, 0, 0, 3, 0, 0));
    queue_item(mk(MODE_QUERY, 0, 0, 0, 0, 0, 1, 2));
    wait_drained();

    // register extremes: 0 acts as 1, 15 acts as 8
    write_reg(CFG_ROWS, 4'd0);
    write_reg(CFG_COLS, 4'd15);
    queue_item(mk(MODE_QUERY, 0, 0, 0, 0, 0, 0, 7));
    queue_item(mk(MODE_QUERY, 0, 0, 0, 1, 0, 0, 0));
    wait_drained();
    write_reg(CFG_ROWS, 4'd15);
    write_reg(CFG_COLS, 4'd0);
    queue_item(mk(MODE_QUERY, 0, 0, 0, 7, 0, 0, 0));
    wait_drained();

    // random phases across sizes and idle patterns
    write_reg(CFG_ROWS, 4'd8);
    write_reg(CFG_COLS, 4'd8);
    run_phase(20, 0, 0);
    write_reg(CFG_ROWS, 4'd3);
    write_reg(CFG_COLS, 4'd5);
    run_held_phase(30, 74, 0);
    write_reg(CFG_ROWS, 4'd1);
    write_reg(CFG_COLS, 4'd8);
    run_phase(25, 0, 74);
    write_reg(CFG_ROWS, 4'd8);
    write_reg(CFG_COLS, 4'd4);
    run_phase(30, 36, 36);
    write_reg(CFG_ROWS, 4'd8);
    write_reg(CFG_COLS, 4'd8);
    run_phase(20, 0, 0);

    $display("covered %0d items (%0d queries, %0d unreachable) and %0d path cells",
             n_items, n_queries, n_notfound, n_cells);
    $display("grid sizes 1x1 through 8x8 with register clamping and idle/stall mixes");
    if (n_err == 0) begin
      $display("grid_dijkstra_path verification clean");
    end else begin
      $display("%0d mismatches", n_err);
      $display("grid_dijkstra_path verification failed");
    end
    $finish;
  end

  // about 145 items are driven, some under stalls; the limit sits well above that
  initial begin
    #100ms;
    $display("grid_dijkstra_path verification failed");
    $finish;
  end
endmodule
